FILE: rtl/rts_pkg.sv
// package with types and constants for the rebalance trigger simulator
`timescale 1ns / 1ps
package rts_pkg;

  localparam int unsigned LoadW = 32;
  localparam int unsigned AccW  = 48;
  localparam int unsigned ProcW = 13;
  localparam int unsigned PerW  = 16;
  localparam int unsigned DivW  = 46;
  localparam int unsigned CntW  = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CntW-1:0] DivStepsShort = CntW'(LoadW);
  localparam logic [CntW-1:0] DivStepsLong  = CntW'(DivW);

  localparam logic [CfgIdxW-1:0] CfgTriggerMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRebalanceCost   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgProcessorCount  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInitialWorkload = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRebalancePeriod = 3'd4;

  localparam logic [1:0] ModeImbalance = 2'd0;
  localparam logic [1:0] ModeImbGap    = 2'd1;
  localparam logic [1:0] ModePeriod    = 2'd2;
  localparam logic [1:0] ModeRequest   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_DECIDE,
    ST_MUL,
    ST_REBDIV,
    ST_REB,
    ST_ITER,
    ST_APPLY,
    ST_DONE,
    ST_DIV
  } state_e;

  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
  endfunction

endpackage

FILE: rtl/rebalance_trigger_simulator.sv
// rebalance trigger simulator top level with shared iterative divider
// a word runs decide, iter, div, apply, done; a restart or first word runs div, init before decide,
// a rebalance mul, rebdiv, div, reb before iter; the restoring divider (one quotient bit per cycle,
// 32 steps, 46 on a rebalance) is shared; the next word is taken once the result is registered
// reset: async active low, config to defaults, run state to zero except peak and datapath regs
`timescale 1ns / 1ps
module rebalance_trigger_simulator
  import rts_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // load_change
  input  logic [1:0]    s_axis_tuser,   // rebalance_request, restart
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // imbalance_total, elapsed_time, peak_load
  output logic          m_axis_tuser    // rebalanced
);

  state_e state_q, state_d, ret_q, ret_d;

  logic [1:0]       mode_q, mode_d;
  logic [LoadW-1:0] cost_q, cost_d;
  logic [ProcW-1:0] procs_q, procs_d;
  logic [LoadW-1:0] init_q, init_d;
  logic [PerW-1:0]  period_q, period_d;

  logic [LoadW-1:0] max_q, max_d, avg_q, avg_d, peak_q, peak_d;
  logic [AccW-1:0]  imb_q, imb_d, time_q, time_d;
  logic [PerW-1:0]  phase_q, phase_d;
  logic             started_q, started_d;

  logic signed [LoadW-1:0] delta_q, delta_d;
  logic             req_q, req_d, first_q, first_d, fire_q, fire_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]  div_q, div_d;
  logic [ProcW-1:0] rem_q, rem_d;
  logic [44:0]      prod_q, prod_d;

  logic             m_valid_q, m_valid_d, m_user_q, m_user_d;
  logic [127:0]     m_data_q, m_data_d;

  logic [ProcW-1:0] p;
  logic [PerW-1:0]  per;
  logic [LoadW-1:0] gap;
  logic             fire;
  logic [ProcW:0]   trial;
  logic             ge;
  logic [LoadW-1:0] dmag;
  logic signed [LoadW+1:0] avg_sum, max_sum, qs;
  logic [LoadW-1:0] avg_new, max_new;
  logic [PerW:0]    phase_inc;
  logic             accept;

  assign p      = (procs_q == '0) ? ProcW'(1) : procs_q;
  assign per    = (period_q == '0) ? PerW'(1) : period_q;
  assign gap    = (max_q > avg_q) ? max_q - avg_q : '0;
  assign trial  = {rem_q, div_q[DivW-1]};
  assign ge     = trial >= {1'b0, p};
  assign dmag   = delta_q[LoadW-1] ? (~delta_q + LoadW'(1)) : delta_q;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (mode_q)
      ModeImbalance: fire = !first_q && (imb_q > {16'd0, cost_q});
      ModeImbGap:    fire = !first_q &&
                       (({1'b0, imb_q} + {17'd0, gap}) > {17'd0, cost_q});
      ModePeriod:    fire = !first_q && (phase_q == '0);
      ModeRequest:   fire = req_q;
      default:       fire = 1'b0;
    endcase
  end

  // signed quotient of delta by processor count
  assign qs      = delta_q[LoadW-1] ? -$signed({2'b00, div_q[LoadW-1:0]})
                                    : $signed({2'b00, div_q[LoadW-1:0]});
  assign avg_sum = $signed({2'b00, avg_q}) + qs;
  assign max_sum = $signed({2'b00, max_q}) + $signed({{2{delta_q[LoadW-1]}}, delta_q});
  assign avg_new = avg_sum[LoadW+1] ? '0 : (avg_sum[LoadW] ? '1 : avg_sum[LoadW-1:0]);
  assign max_new = max_sum[LoadW+1] ? '0 : (max_sum[LoadW] ? '1 : max_sum[LoadW-1:0]);
  assign phase_inc = {1'b0, phase_q} + (PerW+1)'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) begin
                   state_d = (s_axis_tuser[1] || !started_q) ? ST_DIV : ST_DECIDE;
                 end
      ST_INIT:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = fire ? ST_MUL : ST_ITER;
      ST_MUL:    state_d = ST_REBDIV;
      ST_REBDIV: state_d = ST_DIV;
      ST_REB:    state_d = ST_ITER;
      ST_ITER:   state_d = ST_DIV;
      ST_APPLY:  state_d = ST_DONE;
      ST_DONE:   if (!m_valid_q || m_axis_tready) begin
                   state_d = ST_IDLE;
                 end
      ST_DIV:    if (cnt_q == CntW'(1)) begin
                   state_d = ret_q;
                 end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ret_d     = ret_q;
    mode_d    = mode_q;
    cost_d    = cost_q;
    procs_d   = procs_q;
    init_d    = init_q;
    period_d  = period_q;
    max_d     = max_q;
    avg_d     = avg_q;
    peak_d    = peak_q;
    imb_d     = imb_q;
    time_d    = time_q;
    phase_d   = phase_q;
    started_d = started_q;
    delta_d   = delta_q;
    req_d     = req_q;
    first_d   = first_q;
    fire_d    = fire_q;
    cnt_d     = cnt_q;
    div_d     = div_q;
    rem_d     = rem_q;
    prod_d    = prod_q;
    m_valid_d = m_valid_q;
    m_user_d  = m_user_q;
    m_data_d  = m_data_q;
    s_axis_tready = (state_q == ST_IDLE);

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTriggerMode:     mode_d   = cfg_data_i[1:0];
        CfgRebalanceCost:   cost_d   = cfg_data_i;
        CfgProcessorCount:  procs_d  = cfg_data_i[ProcW-1:0];
        CfgInitialWorkload: init_d   = cfg_data_i;
        CfgRebalancePeriod: period_d = cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          delta_d = s_axis_tdata;
          req_d   = s_axis_tuser[0];
          first_d = s_axis_tuser[1] || !started_q;
          div_d   = {init_q, 14'd0};
          rem_d   = '0;
          cnt_d   = DivStepsShort;
          ret_d   = ST_INIT;
        end
      end
      ST_INIT: begin
        max_d     = div_q[LoadW-1:0];
        avg_d     = div_q[LoadW-1:0];
        imb_d     = '0;
        time_d    = '0;
        phase_d   = '0;
        started_d = 1'b1;
      end
      ST_DECIDE: fire_d = fire;
      ST_MUL:    prod_d = (p - ProcW'(1)) * avg_q;
      ST_REBDIV: begin
        div_d = {1'b0, prod_q} + {14'd0, max_q};
        rem_d = '0;
        cnt_d = DivStepsLong;
        ret_d = ST_REB;
      end
      ST_REB: begin
        max_d  = div_q[LoadW-1:0];
        avg_d  = div_q[LoadW-1:0];
        imb_d  = '0;
        time_d = sat_add(time_q, {16'd0, cost_q});
      end
      ST_ITER: begin
        peak_d = max_q;
        time_d = sat_add(time_q, {16'd0, max_q});
        imb_d  = sat_add(imb_q, {16'd0, gap});
        div_d  = {dmag, 14'd0};
        rem_d  = '0;
        cnt_d  = DivStepsShort;
        ret_d  = ST_APPLY;
      end
      ST_APPLY: begin
        avg_d   = avg_new;
        max_d   = (max_new < avg_new) ? avg_new : max_new;
        phase_d = (phase_inc >= {1'b0, per}) ? '0 : phase_inc[PerW-1:0];
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = fire_q;
          m_data_d  = {peak_q, time_q, imb_q};
        end
      end
      ST_DIV: begin
        rem_d = ge ? ProcW'(trial - {1'b0, p}) : trial[ProcW-1:0];
        div_d = {div_q[DivW-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      mode_q    <= ModeImbalance;
      cost_q    <= '0;
      procs_q   <= ProcW'(1);
      init_q    <= '0;
      period_q  <= PerW'(100);
      max_q     <= '0;
      avg_q     <= '0;
      imb_q     <= '0;
      time_q    <= '0;
      phase_q   <= '0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      mode_q    <= mode_d;
      cost_q    <= cost_d;
      procs_q   <= procs_d;
      init_q    <= init_d;
      period_q  <= period_d;
      max_q     <= max_d;
      avg_q     <= avg_d;
      imb_q     <= imb_d;
      time_q    <= time_d;
      phase_q   <= phase_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    peak_q   <= peak_d;
    delta_q  <= delta_d;
    req_q    <= req_d;
    first_q  <= first_d;
    fire_q   <= fire_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    prod_q   <= prod_d;
    m_user_q <= m_user_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero step count");

  a_max_ge_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && started_q) |-> (max_q >= avg_q))
    else $error("max load below average between words");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> m_axis_tvalid)
    else $error("result not registered at end of word");

endmodule

FILE: tb/tb_rebalance_trigger_simulator.sv
// testbench for the rebalance trigger simulator: directed corners, output stall, random runs
`timescale 1ns / 1ps
module tb_rebalance_trigger_simulator
  import rts_pkg::*;
();

  typedef struct packed {
    logic        rebalanced;
    logic [47:0] imbalance_total;
    logic [47:0] elapsed_time;
    logic [31:0] peak_load;
  } iter_result_t;

  localparam logic [CfgIdxW-1:0] CfgUnusedFirst = 3'd5;
  localparam longint unsigned LoadMax = 64'hFFFF_FFFF;
  localparam longint unsigned AccMax = 64'hFFFF_FFFF_FFFF;
  localparam int RandomPerBlock = 113;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 150;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [2:0]    cfg_idx_i;
  logic [31:0]   cfg_data_i;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [31:0]   s_axis_tdata;   // load_change
  logic [1:0]    s_axis_tuser;   // rebalance_request, restart
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [127:0]  m_axis_tdata;   // imbalance_total, elapsed_time, peak_load
  logic          m_axis_tuser;   // rebalanced

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;

  // predictor copy of the registers and the run state
  logic [1:0]  trig_mode;
  logic [31:0] rebal_cost;
  logic [12:0] proc_count;
  logic [31:0] init_work;
  logic [15:0] rebal_period;
  logic [31:0] peak_ld;
  logic [31:0] mean_ld;
  logic [47:0] imb_sum;
  logic [47:0] time_sum;
  logic [15:0] phase_cnt;
  logic        run_started;

  iter_result_t pending_results[$];

  rebalance_trigger_simulator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [31:0] clamp_load(input longint v);
    if (v < 0) return '0;
    if (v > longint'(LoadMax)) return '1;
    return v[31:0];
  endfunction

  function automatic logic [47:0] acc_add_sat(input logic [47:0] a, input longint unsigned b);
    longint unsigned s;
    s = {16'b0, a} + b;
    return (s > AccMax) ? '1 : s[47:0];
  endfunction

  task automatic model_reset();
    trig_mode    = ModeImbalance;
    rebal_cost   = '0;
    proc_count   = 13'd1;
    init_work    = '0;
    rebal_period = 16'd100;
    peak_ld      = '0;
    mean_ld      = '0;
    imb_sum      = '0;
    time_sum     = '0;
    phase_cnt    = '0;
    run_started  = 1'b0;
  endtask

  task automatic predict_iteration(input logic [31:0] change, input logic rebal_req,
                                   input logic new_run);
    longint unsigned p;
    longint unsigned per;
    longint unsigned gap;
    longint delta;
    logic first;
    logic fire;
    iter_result_t r;
    p = (proc_count == 0) ? 1 : proc_count;
    per = (rebal_period == 0) ? 1 : rebal_period;
    delta = longint'($signed(change));
    first = new_run || !run_started;
    if (first) begin
      peak_ld = 32'({32'b0, init_work} / p);
      mean_ld = peak_ld;
      imb_sum = '0;
      time_sum = '0;
      phase_cnt = '0;
      run_started = 1'b1;
    end
    gap = (peak_ld > mean_ld) ? {32'b0, peak_ld} - {32'b0, mean_ld} : 0;
    case (trig_mode)
      ModeImbalance: fire = !first && (imb_sum > rebal_cost);
      ModeImbGap:    fire = !first && ({16'b0, imb_sum} + gap > {32'b0, rebal_cost});
      ModePeriod:    fire = !first && (phase_cnt == 0);
      default:       fire = rebal_req;
    endcase
    if (fire) begin
      peak_ld = 32'(((p - 1) * {32'b0, mean_ld} + {32'b0, peak_ld}) / p);
      mean_ld = peak_ld;
      imb_sum = '0;
      time_sum = acc_add_sat(time_sum, {32'b0, rebal_cost});
    end
    r.peak_load = peak_ld;
    time_sum = acc_add_sat(time_sum, {32'b0, peak_ld});
    gap = (peak_ld > mean_ld) ? {32'b0, peak_ld} - {32'b0, mean_ld} : 0;
    imb_sum = acc_add_sat(imb_sum, gap);
    mean_ld = clamp_load(longint'({32'b0, mean_ld}) + delta / longint'(p));
    peak_ld = clamp_load(longint'({32'b0, peak_ld}) + delta);
    if (peak_ld < mean_ld) peak_ld = mean_ld;
    phase_cnt = ({48'b0, phase_cnt} + 1 >= per) ? '0 : phase_cnt + 16'd1;
    r.rebalanced = fire;
    r.imbalance_total = imb_sum;
    r.elapsed_time = time_sum;
    pending_results = {pending_results, r};
  endtask

  task automatic check_field(input string what, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    iter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with no iteration pending, actual %h %h", $time,
                 m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("rebalanced", want.rebalanced, m_axis_tuser);
        check_field("imbalance_total", want.imbalance_total, m_axis_tdata[47:0]);
        check_field("elapsed_time", want.elapsed_time, m_axis_tdata[95:48]);
        check_field("peak_load", want.peak_load, m_axis_tdata[127:96]);
      end
    end
  end

  // result side: random stall, long hold-off on request
  initial begin
    int hold_len;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_len = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgTriggerMode:     trig_mode = data[1:0];
      CfgRebalanceCost:   rebal_cost = data;
      CfgProcessorCount:  proc_count = data[12:0];
      CfgInitialWorkload: init_work = data;
      CfgRebalancePeriod: rebal_period = data[15:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [31:0] change, input logic rebal_req, input logic new_run);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= change;
    s_axis_tuser <= {new_run, rebal_req};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_iteration(change, rebal_req, new_run);
  endtask

  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_change();
    logic [31:0] mag;
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4, 5: mag = $urandom_range(32'h10_0000);
      6, 7: return $urandom;
      default: mag = $urandom_range(32'h400_0000);
    endcase
    return $urandom_range(1) ? mag : -mag;
  endfunction

  task automatic pick_config(input logic [1:0] mode);
    logic [31:0] cost;
    logic [31:0] work;
    logic [12:0] pc;
    logic [15:0] per;
    case ($urandom_range(5))
      0: cost = '0;
      1: cost = '1;
      2: cost = $urandom;
      default: cost = $urandom_range(32'h40_0000);
    endcase
    case ($urandom_range(7))
      0: pc = '0;
      1: pc = 13'd1;
      2: pc = 13'd4096;
      3: pc = 13'h1FFF;
      4: pc = 13'($urandom);
      default: pc = 13'($urandom_range(1, 64));
    endcase
    case ($urandom_range(4))
      0: work = '0;
      1: work = '1;
      default: work = $urandom;
    endcase
    case ($urandom_range(5))
      0: per = '0;
      1: per = 16'hFFFF;
      2: per = 16'($urandom);
      default: per = 16'($urandom_range(1, 20));
    endcase
    cfg_write(CfgTriggerMode, {30'b0, mode});
    cfg_write(CfgRebalanceCost, cost);
    cfg_write(CfgProcessorCount, {19'b0, pc});
    cfg_write(CfgInitialWorkload, work);
    cfg_write(CfgRebalancePeriod, {16'b0, per});
    if ($urandom_range(3) == 0) cfg_write(CfgUnusedFirst + 3'($urandom_range(2)), $urandom);
  endtask

  task automatic test_directed_corners();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // reset defaults, first word arrives without a restart
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_word(32'h8000_0000, 1'b1, 1'b0);
    send_word(32'h0001_0000, 1'b1, 1'b1);
    finish_stream();
    // request mode, zero processor count, largest workload and cost
    cfg_write(CfgTriggerMode, {30'b0, ModeRequest});
    cfg_write(CfgProcessorCount, '0);
    cfg_write(CfgInitialWorkload, 32'hFFFF_FFFF);
    cfg_write(CfgRebalanceCost, 32'hFFFF_FFFF);
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_word(32'h8000_0000, 1'b1, 1'b0);
    send_word(32'h8000_0000, 1'b0, 1'b0);
    send_word(32'h8000_0000, 1'b0, 1'b0);
    finish_stream();
    // period mode with zero period and the widest processor count
    cfg_write(CfgTriggerMode, {30'b0, ModePeriod});
    cfg_write(CfgRebalancePeriod, '0);
    cfg_write(CfgProcessorCount, 32'h1FFF);
    send_word(32'h0123_4567, 1'b0, 1'b1);
    send_word(32'hFFF0_0000, 1'b0, 1'b0);
    send_word(32'h0100_0000, 1'b1, 1'b0);
    send_word(32'h8000_0000, 1'b0, 1'b0);
    finish_stream();
    // period shrinks below the running phase
    cfg_write(CfgRebalancePeriod, 32'd5);
    cfg_write(CfgProcessorCount, 32'd3);
    send_word(32'h0002_0000, 1'b0, 1'b1);
    send_word(32'hFFFF_0000, 1'b0, 1'b0);
    send_word(32'h0003_0000, 1'b0, 1'b0);
    finish_stream();
    cfg_write(CfgRebalancePeriod, 32'd2);
    send_word(32'h0001_8000, 1'b0, 1'b0);
    send_word(32'h0000_0001, 1'b0, 1'b0);
    finish_stream();
    // imbalance plus gap with zero cost
    cfg_write(CfgTriggerMode, {30'b0, ModeImbGap});
    cfg_write(CfgRebalanceCost, '0);
    cfg_write(CfgProcessorCount, 32'd4);
    cfg_write(CfgInitialWorkload, 32'h0010_0000);
    send_word(32'h0000_0000, 1'b0, 1'b1);
    send_word(32'h0001_0000, 1'b0, 1'b0);
    send_word(32'h0001_0000, 1'b0, 1'b0);
    send_word(32'hFFFF_0000, 1'b0, 1'b0);
    finish_stream();
    // writes past the register list change nothing
    cfg_write(CfgUnusedFirst, $urandom);
    cfg_write(CfgUnusedFirst + 3'd1, 32'hFFFF_FFFF);
    cfg_write(CfgUnusedFirst + 3'd2, $urandom);
    send_word(32'h0004_0000, 1'b1, 1'b0);
    finish_stream();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pick_config(ModeRequest);
    hold_request = HoldCycles;
    for (int i = 0; i < 24; i++) send_word(pick_change(), 1'($urandom_range(1)), i == 0);
    finish_stream();
  endtask

  task automatic test_random_modes();
    int idle_set [4];
    int stall_set [4];
    idle_set = '{0, 45, 0, 25};
    stall_set = '{0, 0, 45, 25};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int m = 0; m < 4; m++) begin
        pick_config(2'(m));
        for (int i = 0; i < RandomPerBlock; i++)
          send_word(pick_change(), 1'($urandom_range(1)), $urandom_range(39) == 0);
        finish_stream();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_output_backpressure();
    test_random_modes();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("%0t: timeout", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: rebalance_trigger_simulator.f
rtl/rts_pkg.sv
rtl/rebalance_trigger_simulator.sv
tb/tb_rebalance_trigger_simulator.sv
